@@ rtl/modular_exponentiation_unit_macros.svh @@
// assertion macros for the rtl
`ifndef MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MEXP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mexp assertion failed");

// antecedent implies consequent in the next cycle
`define MEXP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mexp assertion failed");

`endif

@@ rtl/mexp_pkg.sv @@
package mexp_pkg;
  localparam int unsigned MEXP_WIDTH = 32;
endpackage

@@ rtl/mexp_in_if.sv @@
interface mexp_in_if #(parameter int unsigned W = mexp_pkg::MEXP_WIDTH);
  logic         valid;
  logic         ready;
  logic [W-1:0] base;
  logic [W-1:0] exponent;
  modport source (output valid, base, exponent, input ready);
  modport sink (input valid, base, exponent, output ready);
endinterface

@@ rtl/mexp_out_if.sv @@
interface mexp_out_if #(parameter int unsigned W = mexp_pkg::MEXP_WIDTH);
  logic         valid;
  logic         ready;
  logic [W-1:0] result;
  logic         modulus_error;
  modport source (output valid, result, modulus_error, input ready);
  modport sink (input valid, result, modulus_error, output ready);
endinterface

@@ rtl/modular_exponentiation_unit.sv @@
// Modular exponentiation, right-to-left binary method: result = base^exponent mod modulus.
// The modulus comes from the single configuration register (cfg_we / cfg_wdata) and must
// only be written while no transaction is in flight. The datapath is a pure pipeline with
// no multiplier: WIDTH stages reduce the base bit by bit, then for each of the WIDTH
// exponent bits WIDTH interleaved shift-add-reduce stages form acc*b and b*b mod n side by
// side. A transaction passes WIDTH + WIDTH*WIDTH + 1 registers, the last of them the output
// register; a new transaction can enter every cycle unless a stalled output holds the
// pipeline. The whole pipeline advances together whenever the output register is empty
// or being taken, so a stalled output freezes every stage. A zero exponent returns 1; a
// zero modulus returns 0 with modulus_error set.
`include "modular_exponentiation_unit_macros.svh"

module modular_exponentiation_unit #(
  parameter int unsigned WIDTH = mexp_pkg::MEXP_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [WIDTH-1:0] cfg_wdata,
  mexp_in_if.sink          in_ch,
  mexp_out_if.source       out_ch
);
  import mexp_pkg::*;

  localparam int unsigned W = WIDTH;
  // base reduction stages followed by the square-and-multiply stages
  localparam int unsigned NSTG = W + W * W;

  typedef struct packed {
    logic         v;    // stage holds a transaction
    logic [W-1:0] acc;  // running result
    logic [W-1:0] b;    // current base power
    logic [W-1:0] e;    // exponent
    logic [W-1:0] pa;   // partial acc*b
    logic [W-1:0] ps;   // partial b*b
  } stage_t;

  stage_t st_r [NSTG+1];
  stage_t st_nxt [NSTG];

  logic [W-1:0] modulus_r;
  logic         adv;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= '0;
    end else if (cfg_we) begin
      modulus_r <= cfg_wdata;
    end
  end

  // global advance: output register empty or being taken
  assign adv         = !st_r[NSTG].v || out_ch.ready;
  assign in_ch.ready = adv;

  // next value of every stage
  always_comb begin
    logic [W+1:0] n_x;
    logic [W+1:0] a2;
    logic [W+1:0] s2;
    logic         x;
    int unsigned  k;
    n_x = {2'b00, modulus_r};
    a2  = '0;
    s2  = '0;
    x   = 1'b0;
    k   = 0;
    for (int i = 0; i < NSTG; i++) begin
      st_nxt[i] = st_r[i];
    end
    // r = (2r + base bit) mod n, below 2n before the subtract
    for (int j = 0; j < W; j++) begin
      x  = st_r[j].b[W-1-j];
      a2 = {1'b0, st_r[j].pa, 1'b0} + {{(W+1){1'b0}}, x};
      if (a2 >= n_x) begin
        a2 = a2 - n_x;
      end
      st_nxt[j].pa = a2[W-1:0];
      if (j == W - 1) begin
        st_nxt[j].b  = a2[W-1:0];
        st_nxt[j].pa = '0;
      end
    end
    // interleaved multiply: p = (2p + x*operand) mod n, below 3n
    for (int bi = 0; bi < W; bi++) begin
      for (int sj = 0; sj < W; sj++) begin
        k  = W + bi * W + sj;
        x  = st_r[k].b[W-1-sj];
        a2 = {1'b0, st_r[k].pa, 1'b0} + (x ? {2'b00, st_r[k].acc} : '0);
        s2 = {1'b0, st_r[k].ps, 1'b0} + (x ? {2'b00, st_r[k].b} : '0);
        if (a2 >= n_x) begin
          a2 = a2 - n_x;
        end
        if (a2 >= n_x) begin
          a2 = a2 - n_x;
        end
        if (s2 >= n_x) begin
          s2 = s2 - n_x;
        end
        if (s2 >= n_x) begin
          s2 = s2 - n_x;
        end
        st_nxt[k].pa = a2[W-1:0];
        st_nxt[k].ps = s2[W-1:0];
        if (sj == W - 1) begin
          // end of this exponent bit: commit multiply, take the square
          if (st_r[k].e[bi]) begin
            st_nxt[k].acc = a2[W-1:0];
          end
          st_nxt[k].b  = s2[W-1:0];
          st_nxt[k].pa = '0;
          st_nxt[k].ps = '0;
        end
      end
    end
  end

  // entry stage and pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NSTG; i++) begin
        st_r[i] <= '0;
      end
    end else if (adv) begin
      st_r[0].v   <= in_ch.valid;
      st_r[0].acc <= {{(W-1){1'b0}}, 1'b1};
      st_r[0].b   <= in_ch.base;
      st_r[0].e   <= in_ch.exponent;
      st_r[0].pa  <= '0;
      st_r[0].ps  <= '0;
      for (int i = 0; i < NSTG; i++) begin
        st_r[i+1] <= st_nxt[i];
      end
    end
  end

  // output: zero modulus is flagged, result forced to 0
  assign out_ch.valid         = st_r[NSTG].v;
  assign out_ch.modulus_error = (modulus_r == '0);
  assign out_ch.result        = (modulus_r == '0) ? '0 : st_r[NSTG].acc;

  `MEXP_ASSERT_NEXT(a_entry_valid, in_ch.valid && in_ch.ready, st_r[0].v)
  `MEXP_ASSERT_SAME(a_err_zero, out_ch.valid && out_ch.modulus_error, out_ch.result == '0)
  `MEXP_ASSERT_NEXT(a_stall_hold, !adv, $stable(st_r[NSTG]) && $stable(st_r[0].v))

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import mexp_pkg::*;

  localparam int unsigned W          = MEXP_WIDTH;
  // pipeline depth given at the head of the block: WIDTH + WIDTH*WIDTH + 1
  localparam int unsigned PIPE_DEPTH = W + W * W + 1;
  localparam int unsigned DRAIN      = PIPE_DEPTH + 64;
  localparam int unsigned CYCLE_CAP  = 600000;

  typedef struct packed {
    logic [W-1:0] base;
    logic [W-1:0] exponent;
  } pow_req_t;

  typedef struct packed {
    logic [W-1:0] result;
    logic         modulus_error;
  } pow_rsp_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [W-1:0] cfg_wdata = '0;

  mexp_in_if  #(.W(W)) in_ch ();
  mexp_out_if #(.W(W)) out_ch ();

  // requests waiting to be driven, answers waiting to come back
  pow_req_t     req_q[$];
  pow_rsp_t     answer_q[$];
  // shadow copy of the modulus register
  logic [W-1:0] modulus_shadow = '0;

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  cycle_cnt = 0;
  int unsigned  mismatch_cnt = 0;
  int unsigned  orphan_cnt = 0;
  int unsigned  checked_cnt = 0;
  int unsigned  error_rsp_cnt = 0;

  always #6 clk = ~clk;

  modular_exponentiation_unit #(.WIDTH(W)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // right-to-left binary power with double-width products
  function automatic pow_rsp_t predict_power(logic [W-1:0] base, logic [W-1:0] exponent,
                                              logic [W-1:0] modulus);
    pow_rsp_t        rsp;
    longint unsigned n;
    longint unsigned b;
    longint unsigned acc;
    logic [W-1:0]    e;
    n = modulus;
    e = exponent;
    acc = 1;
    rsp = '0;
    if (n == 0) begin
      rsp.modulus_error = 1'b1;
      return rsp;
    end
    b = base % n;
    for (int i = 0; i < W; i++) begin
      if (e == 0) break;
      if (e[0]) acc = (acc * b) % n;
      b = (b * b) % n;
      e = e >> 1;
    end
    // zero exponent keeps acc at 1, even for modulus one
    rsp.result = acc[W-1:0];
    return rsp;
  endfunction

  // driver: next request goes out when the slot is free, with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.base     <= '0;
      in_ch.exponent <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        pow_req_t r;
        r = req_q.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.base     <= r.base;
        in_ch.exponent <= r.exponent;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: check returned transactions, then record newly accepted ones
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (answer_q.size() == 0) begin
          orphan_cnt++;
          if (mismatch_cnt + orphan_cnt <= 10)
            $display("unexpected transaction: result %h err %b", out_ch.result,
                     out_ch.modulus_error);
        end else begin
          pow_rsp_t want;
          want = answer_q.pop_front();
          checked_cnt++;
          if (want.modulus_error) error_rsp_cnt++;
          if (want.result !== out_ch.result || want.modulus_error !== out_ch.modulus_error)
          begin
            mismatch_cnt++;
            if (mismatch_cnt + orphan_cnt <= 10)
              $display("mismatch: want result %h err %b, got result %h err %b",
                       want.result, want.modulus_error, out_ch.result, out_ch.modulus_error);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        answer_q.push_back(predict_power(in_ch.base, in_ch.exponent, modulus_shadow));
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("modular_exponentiation_unit test failed");
      $finish;
    end
  end

  task automatic add_req(logic [W-1:0] base, logic [W-1:0] exponent);
    pow_req_t r;
    r.base = base;
    r.exponent = exponent;
    req_q.push_back(r);
  endtask

  // write the modulus; only called with the pipeline empty
  task automatic set_modulus(logic [W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    modulus_shadow <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until all requests are out and answered, then let the pipe empty
  task automatic drain_all();
    while (req_q.size() > 0 || in_ch.valid || answer_q.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic random_batch(int unsigned count, logic [W-1:0] modulus);
    logic [W-1:0] b;
    logic [W-1:0] e;
    for (int i = 0; i < count; i++) begin
      b = $urandom();
      case ($urandom_range(3))
        0: e = $urandom_range(15);
        1: e = $urandom() >> $urandom_range(31);
        default: e = $urandom();
      endcase
      // sometimes a base right at or around the modulus
      if ($urandom_range(7) == 0) b = modulus + $urandom_range(2) - 1;
      add_req(b, e);
    end
  endtask

  initial begin
    logic [W-1:0] m;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: odd large modulus, field extremes and the zero exponent
    set_modulus(32'hFFFF_FFFB);
    add_req('0, '0);
    add_req('1, '0);
    add_req('0, 32'd5);
    add_req('1, '1);
    add_req(32'hFFFF_FFFB, 32'd3);
    add_req(32'hFFFF_FFFC, 32'd7);
    add_req(32'd2, 32'd31);
    add_req(32'd2, 32'd64);
    add_req(32'hAAAA_AAAA, 32'h5555_5555);
    add_req(32'h5555_5555, 32'hAAAA_AAAA);
    add_req(32'd1, '1);
    add_req(32'h8000_0000, 32'h8000_0000);
    drain_all();

    // modulus one: zero exponent still yields one
    set_modulus(32'd1);
    add_req(32'd7, '0);
    add_req(32'd7, 32'd1);
    add_req('1, '1);
    drain_all();

    // zero modulus raises the error flag
    set_modulus('0);
    add_req(32'd3, 32'd4);
    add_req('1, '0);
    add_req('0, '1);
    drain_all();

    // random phases across several moduli and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  m = '1; end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  m = $urandom() | 32'h8000_0001; end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; m = $urandom_range(2, 1000); end
        3: begin send_idle_pct = 37; recv_stall_pct = 37; m = $urandom(); end
        4: begin send_idle_pct = 0;  recv_stall_pct = 0;  m = $urandom() & 32'hFFFF_FFFE; end
        default: begin send_idle_pct = 47; recv_stall_pct = 47; m = ~$urandom(); end
      endcase
      if (m == 0) m = 32'd97;
      set_modulus(m);
      random_batch(ph == 5 ? 15 : 22, m);
      drain_all();
    end

    $display("checked %0d transactions over %0d moduli incl. zero and one, %0d error answers",
             checked_cnt, 9, error_rsp_cnt);
    $display("mismatches %0d, unexpected transactions %0d, idle mixes of sender and receiver",
             mismatch_cnt, orphan_cnt);
    if (mismatch_cnt == 0 && orphan_cnt == 0 && answer_q.size() == 0) begin
      $display("modular_exponentiation_unit test passed");
    end else begin
      $display("modular_exponentiation_unit test failed");
    end
    $finish;
  end

endmodule
